### sv/lidstop_pkg.sv
// shared types, constants and tables for the lidar obstacle stop gate
package lidstop_pkg;

  // field widths
  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int CMD_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // default parameter values
  localparam int DEF_MAX_BEAMS    = 4096;
  localparam int DEF_CORDIC_STEPS = 16;

  // range times inverse cordic gain, q30
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_INV_Q30 = 30'd652032874;
  localparam int PROD_W = GAIN_W + RANGE_W;

  // serial datapath widths
  localparam int XY_W   = 48;
  localparam int KCNT_W = 6;
  localparam int Z_W    = 32;
  localparam int ZK_W   = 5;
  localparam int ATAN_N = 24;
  localparam int ATAN_IDX_W = 5;

  // hazard limits, mm with 30 fraction bits
  localparam logic signed [XY_W-1:0] FRONT_X_LIM = 48'sd966367641600;
  localparam logic signed [XY_W-1:0] FRONT_X_NEG = -48'sd966367641600;
  localparam logic signed [XY_W-1:0] FRONT_Y_LIM = 48'sd805306368000;
  localparam logic signed [XY_W-1:0] FRONT_Y_NEG = -48'sd805306368000;
  localparam logic [RANGE_W-1:0] NEAR_MM = 16'd650;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 8'd3;

  // stop cause codes
  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_NO_BEAM  = 2'd1,
    CAUSE_FRONT    = 2'd2,
    CAUSE_TURN     = 2'd3
  } cause_t;

  // input request
  typedef struct packed {
    logic [RANGE_W-1:0]      range_mm;
    logic                    range_is_nan;
    logic                    range_is_inf;
    logic                    last_beam;
    logic signed [CMD_W-1:0] cmd_linear;
    logic signed [CMD_W-1:0] cmd_angular;
  } beam_t;

  // result request
  typedef struct packed {
    logic signed [CMD_W-1:0] out_linear;
    logic signed [CMD_W-1:0] out_angular;
    logic                    obstacle_stop;
    logic [1:0]              stop_cause;
  } result_t;

  // multiplier results handed to the rotator
  typedef struct packed {
    logic [PROD_W-1:0]  x0;
    logic [ANGLE_W-1:0] bam;
  } mul_res_t;

  // rotator status
  typedef struct packed {
    logic done;
    logic front;
  } cord_res_t;

  // round(atan(2^-i) * 2^32 / 2pi)
  function automatic logic [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/lidstop_mul.sv
// shift-add multiplier: range times inverse cordic gain and beam angle, one bit per cycle
module lidstop_mul
  import lidstop_pkg::*;
#(
  parameter int IDX_W = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RANGE_W-1:0]  range_mm,
  input  logic [IDX_W-1:0]    index,
  input  logic [ANGLE_W-1:0]  angle_start,
  input  logic [ANGLE_W-1:0]  angle_step,
  output logic                done,
  output mul_res_t            res
);

  localparam int CNT_W = $clog2(RANGE_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [RANGE_W-1:0] r_sr;
  logic [IDX_W-1:0]   idx_sr;
  logic [ANGLE_W-1:0] step_sh;
  logic [PROD_W-1:0]  prod;
  logic [ANGLE_W-1:0] ang;
  logic [GAIN_W:0]    upper;

  // one partial product per range bit
  always_comb begin
    upper = {1'b0, prod[PROD_W-1:RANGE_W]} + (r_sr[0] ? {1'b0, GAIN_INV_Q30} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy    <= 1'b1;
        done    <= 1'b0;
        cnt     <= '0;
        r_sr    <= range_mm;
        idx_sr  <= index;
        step_sh <= angle_step;
        prod    <= '0;
        ang     <= angle_start;
      end else if (busy) begin
        prod    <= {upper, prod[RANGE_W-1:1]};
        r_sr    <= r_sr >> 1;
        // angle accumulates step shifted by each index bit, wrapping mod 2^16
        ang     <= ang + (idx_sr[0] ? step_sh : '0);
        step_sh <= step_sh << 1;
        idx_sr  <= idx_sr >> 1;
        cnt     <= cnt + 1'b1;
        done    <= (cnt == CNT_W'(RANGE_W - 1));
        if (cnt == CNT_W'(RANGE_W - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign res.x0  = prod;
  assign res.bam = ang;

endmodule

### sv/lidstop_cordic.sv
// bit-serial cordic rotator with front zone check
module lidstop_cordic
  import lidstop_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mul_res_t           op,
  output cord_res_t          stat
);

  localparam int IT_W = $clog2(CORDIC_STEPS);

  typedef enum logic [1:0] {C_IDLE, C_ROT, C_CHK} cstate_t;

  cstate_t            state;
  logic [XY_W-1:0]    x_sr;
  logic [XY_W-1:0]    y_sr;
  logic [Z_W-1:0]     z_sr;
  logic [KCNT_W-1:0]  k;
  logic [IT_W-1:0]    iter;
  logic               flip;
  logic               dir_q, sx_q, sy_q;
  logic               cx, cy, cz;

  logic               dir_now, sx_now, sy_now;
  logic [KCNT_W:0]    tap;
  logic               in_rng;
  logic               dx, dy, bx, by, bz, at_bit;
  logic               cin_x, cin_y, cin_z;
  logic               sum_x, sum_y, sum_z;
  logic               co_x, co_y, co_z;
  logic [Z_W-1:0]     at_word;
  logic signed [XY_W-1:0] xs, ys;
  logic               front_next;

  // one bit of x and y per cycle, and of z while k is below Z_W, lsb first
  always_comb begin
    dir_now = (k == '0) ? ~z_sr[Z_W-1] : dir_q;
    sx_now  = (k == '0) ? x_sr[XY_W-1] : sx_q;
    sy_now  = (k == '0) ? y_sr[XY_W-1] : sy_q;
    tap     = {1'b0, k} + (KCNT_W+1)'(iter);
    in_rng  = tap < (KCNT_W+1)'(XY_W);
    // arithmetic shift by iter: tap at position iter, sign once past the top
    dx = in_rng ? y_sr[KCNT_W'(iter)] : sy_now;
    dy = in_rng ? x_sr[KCNT_W'(iter)] : sx_now;
    at_word = atan_entry(ATAN_IDX_W'(iter));
    at_bit  = (k < KCNT_W'(Z_W)) ? at_word[k[ZK_W-1:0]] : 1'b0;
    bx = dx ^ dir_now;
    by = dy ^ ~dir_now;
    bz = at_bit ^ dir_now;
    cin_x = (k == '0) ? dir_now : cx;
    cin_y = (k == '0) ? ~dir_now : cy;
    cin_z = (k == '0) ? dir_now : cz;
    sum_x = x_sr[0] ^ bx ^ cin_x;
    sum_y = y_sr[0] ^ by ^ cin_y;
    sum_z = z_sr[0] ^ bz ^ cin_z;
    co_x  = (x_sr[0] & bx) | (x_sr[0] & cin_x) | (bx & cin_x);
    co_y  = (y_sr[0] & by) | (y_sr[0] & cin_y) | (by & cin_y);
    co_z  = (z_sr[0] & bz) | (z_sr[0] & cin_z) | (bz & cin_z);
  end

  // front zone, mirrored when the angle was folded by half a turn
  always_comb begin
    xs = $signed(x_sr);
    ys = $signed(y_sr);
    front_next = (ys > FRONT_Y_NEG) && (ys < FRONT_Y_LIM) &&
                 (flip ? ((xs < 0) && (xs > FRONT_X_NEG))
                       : ((xs > 0) && (xs < FRONT_X_LIM)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      stat.done <= 1'b0;
      k         <= '0;
      iter      <= '0;
    end else begin
      stat.done <= (state == C_CHK);
      unique case (state)
        C_IDLE: begin
          if (start) begin
            x_sr  <= XY_W'(op.x0);
            y_sr  <= '0;
            // second and third quadrants turn by half a turn
            flip  <= op.bam[ANGLE_W-1] ^ op.bam[ANGLE_W-2];
            z_sr  <= {op.bam[ANGLE_W-2], op.bam[ANGLE_W-2:0], {(Z_W-ANGLE_W){1'b0}}};
            k     <= '0;
            iter  <= '0;
            state <= C_ROT;
          end
        end
        C_ROT: begin
          x_sr  <= {sum_x, x_sr[XY_W-1:1]};
          y_sr  <= {sum_y, y_sr[XY_W-1:1]};
          if (k < KCNT_W'(Z_W)) begin
            z_sr <= {sum_z, z_sr[Z_W-1:1]};
          end
          cx    <= co_x;
          cy    <= co_y;
          cz    <= co_z;
          dir_q <= dir_now;
          sx_q  <= sx_now;
          sy_q  <= sy_now;
          if (k == KCNT_W'(XY_W - 1)) begin
            k <= '0;
            if (iter == IT_W'(CORDIC_STEPS - 1)) begin
              state <= C_CHK;
            end else begin
              iter <= iter + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        C_CHK: begin
          stat.front <= front_next;
          state      <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### sv/lidar_obstacle_stop_gate_core.sv
// lidar obstacle stop gate: beam qualification, scan hazards and command gating
// a beam that needs its position runs the shift-add multiply, then the bit-serial cordic,
// 48 bits per step, and the input stalls until the cordic is done
// other beams go in without a stall; after a last beam the finish state sets its result
// the result register lets the next beam in while a result waits to be taken
// synchronous reset sets the registers to their reset values and clears the scan state
module lidar_obstacle_stop_gate_core
  import lidstop_pkg::*;
#(
  parameter int MAX_BEAMS    = DEF_MAX_BEAMS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  beam_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROT, S_FIN} state_t;

  state_t              state;
  logic [RANGE_W-1:0]  range_floor;
  logic [RANGE_W-1:0]  range_ceiling;
  logic [ANGLE_W-1:0]  angle_start;
  logic [ANGLE_W-1:0]  angle_step;
  logic [IDX_W-1:0]    beam_index;
  logic                any_valid;
  logic                front_hit;
  logic                near_hit;
  logic                last_q;
  logic signed [CMD_W-1:0] cmd_lin_q;
  logic signed [CMD_W-1:0] cmd_ang_q;

  logic                accept;
  logic                beam_ok;
  logic                rot_ok;
  logic [IDX_W-1:0]    beam_index_next;
  logic                mul_done;
  mul_res_t            mul_res;
  cord_res_t           cord_stat;
  result_t             result_next;
  logic                lin_pos;
  cause_t              cause;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_floor   <= '0;
      range_ceiling <= '1;
      angle_start   <= '0;
      angle_step    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RANGE_FLOOR:   range_floor   <= cfg_data;
        REG_RANGE_CEILING: range_ceiling <= cfg_data;
        REG_ANGLE_START:   angle_start   <= cfg_data;
        REG_ANGLE_STEP:    angle_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  // beam qualification
  always_comb begin
    beam_ok = (range_ceiling > range_floor) && !in_data.range_is_nan &&
              (in_data.range_is_inf || (in_data.range_mm >= range_floor));
    rot_ok  = beam_ok && !in_data.range_is_inf && (in_data.range_mm < range_ceiling);
    beam_index_next = (beam_index == IDX_W'(MAX_BEAMS - 1)) ? '0 : beam_index + 1'b1;
  end

  lidstop_mul #(
    .IDX_W (IDX_W)
  ) u_mul (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && rot_ok),
    .range_mm    (in_data.range_mm),
    .index       (beam_index),
    .angle_start (angle_start),
    .angle_step  (angle_step),
    .done        (mul_done),
    .res         (mul_res)
  );

  lidstop_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (mul_done),
    .op    (mul_res),
    .stat  (cord_stat)
  );

  // stop decision, in priority order
  always_comb begin
    lin_pos = (cmd_lin_q != '0) && !cmd_lin_q[CMD_W-1];
    if (!any_valid) begin
      cause = CAUSE_NO_BEAM;
    end else if (front_hit && lin_pos) begin
      cause = CAUSE_FRONT;
    end else if (near_hit && (cmd_ang_q != '0)) begin
      cause = CAUSE_TURN;
    end else begin
      cause = CAUSE_NONE;
    end
    result_next.stop_cause    = cause;
    result_next.obstacle_stop = (cause != CAUSE_NONE);
    result_next.out_linear    = (cause != CAUSE_NONE) ? '0 : cmd_lin_q;
    result_next.out_angular   = (cause != CAUSE_NONE) ? '0 : cmd_ang_q;
  end

  // sequencer, scan state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      beam_index <= '0;
      any_valid  <= 1'b0;
      front_hit  <= 1'b0;
      near_hit   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_q     <= in_data.last_beam;
            cmd_lin_q  <= in_data.cmd_linear;
            cmd_ang_q  <= in_data.cmd_angular;
            any_valid  <= any_valid | beam_ok;
            near_hit   <= near_hit | (rot_ok && (in_data.range_mm < NEAR_MM));
            beam_index <= beam_index_next;
            if (rot_ok) begin
              state <= S_MUL;
            end else if (in_data.last_beam) begin
              state <= S_FIN;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (cord_stat.done) begin
            front_hit <= front_hit | cord_stat.front;
            state     <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          // wait for the result register to free up
          if (!out_valid || !out_stall) begin
            out_data   <= result_next;
            out_valid  <= 1'b1;
            beam_index <= '0;
            any_valid  <= 1'b0;
            front_hit  <= 1'b0;
            near_hit   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // multiplier finishes only while the sequencer waits for it
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL)
    else $error("multiplier done outside multiply phase");

  // rotator finishes only while the sequencer waits for it
  a_cord_done_in_rot: assert property (@(posedge clk) disable iff (rst)
    cord_stat.done |-> state == S_ROT)
    else $error("rotator done outside rotate phase");

  // a written result leaves the scan state cleared
  a_scan_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !(out_valid && out_stall)) |=>
      (!any_valid && !front_hit && !near_hit && beam_index == '0 && out_valid))
    else $error("scan state not cleared after result");

  // no beam is taken while the multiplier or rotator is busy
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_ROT) |-> in_stall)
    else $error("beam accepted while position unit busy");

endmodule
